// ===== hw/rtl/d2r_pkg.sv =====
// Shared constants and the numeral step table for the decimal to Roman encoder.
package d2r_pkg;

   localparam int unsigned VALUE_WIDTH  = 12;
   localparam int unsigned SYMBOL_WIDTH = 7;
   localparam int unsigned STEP_WIDTH   = 10;
   localparam int unsigned INDEX_WIDTH  = 4;

   localparam logic [VALUE_WIDTH-1:0] VALUE_LIMIT = 12'd4000;

   localparam logic [SYMBOL_WIDTH-1:0] SYM_NONE = 7'h00;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_M    = 7'h4D;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_D    = 7'h44;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_C    = 7'h43;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_L    = 7'h4C;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_X    = 7'h58;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_V    = 7'h56;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_I    = 7'h49;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_N    = 7'h4E;

   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = 4'd12;

   typedef struct packed {
      logic [STEP_WIDTH-1:0]   amount;
      logic [SYMBOL_WIDTH-1:0] first;
      logic [SYMBOL_WIDTH-1:0] second;
      logic                    pair;
   } step_type;

   // greedy table, largest amount first
   function automatic step_type step_entry(input logic [INDEX_WIDTH-1:0] index);
      step_type entry;
      entry = '{amount: '0, first: SYM_NONE, second: SYM_NONE, pair: 1'b0};
      unique case (index)
         4'd0:    entry = '{amount: 10'd1000, first: SYM_M, second: SYM_NONE, pair: 1'b0};
         4'd1:    entry = '{amount: 10'd900,  first: SYM_C, second: SYM_M,    pair: 1'b1};
         4'd2:    entry = '{amount: 10'd500,  first: SYM_D, second: SYM_NONE, pair: 1'b0};
         4'd3:    entry = '{amount: 10'd400,  first: SYM_C, second: SYM_D,    pair: 1'b1};
         4'd4:    entry = '{amount: 10'd100,  first: SYM_C, second: SYM_NONE, pair: 1'b0};
         4'd5:    entry = '{amount: 10'd90,   first: SYM_X, second: SYM_C,    pair: 1'b1};
         4'd6:    entry = '{amount: 10'd50,   first: SYM_L, second: SYM_NONE, pair: 1'b0};
         4'd7:    entry = '{amount: 10'd40,   first: SYM_X, second: SYM_L,    pair: 1'b1};
         4'd8:    entry = '{amount: 10'd10,   first: SYM_X, second: SYM_NONE, pair: 1'b0};
         4'd9:    entry = '{amount: 10'd9,    first: SYM_I, second: SYM_X,    pair: 1'b1};
         4'd10:   entry = '{amount: 10'd5,    first: SYM_V, second: SYM_NONE, pair: 1'b0};
         4'd11:   entry = '{amount: 10'd4,    first: SYM_I, second: SYM_V,    pair: 1'b1};
         4'd12:   entry = '{amount: 10'd1,    first: SYM_I, second: SYM_NONE, pair: 1'b0};
         default: entry = '{amount: 10'd1,    first: SYM_I, second: SYM_NONE, pair: 1'b0};
      endcase
      return entry;
   endfunction

endpackage

// ===== hw/rtl/decimal_to_roman_numeral_encoder.sv =====
// Top level: serial decimal to Roman numeral encoder.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low;
//   req_value carries the number (0..3999 valid, 4000..4095 flagged error).
//   Characters leave most significant first on rsp_symbol, each shown for one
//   cycle with rsp_valid high; rsp_last marks the final character.
//   Zero gives a single 'N'; an out-of-range value gives a single result with
//   rsp_error high and symbol 0. Both come in the cycle after accept and leave
//   busy low, so a new transaction may follow at once.
//   Other values run a greedy sequencer over a 13-entry table with one shared
//   compare/subtract unit: each cycle it either emits one character or moves
//   to the next table entry (the second character of a pair does both). A
//   transaction emits at most 15 characters, and busy stays high until the
//   final character is out.
//   The receiver cannot stall; results are never held.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   rsp_valid.
module decimal_to_roman_numeral_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [d2r_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                               rsp_valid,
   output logic [d2r_pkg::SYMBOL_WIDTH-1:0]   rsp_symbol,
   output logic                               rsp_last,
   output logic                               rsp_error
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_SECOND
   } state_type;

   state_type                          state_ff, state_in;
   logic [d2r_pkg::VALUE_WIDTH-1:0]    rem_ff, rem_in;
   logic [d2r_pkg::INDEX_WIDTH-1:0]    index_ff, index_in;
   logic [d2r_pkg::SYMBOL_WIDTH-1:0]   pend_ff, pend_in;
   logic                               pend_last_ff, pend_last_in;
   logic                               valid_ff, valid_in;
   logic [d2r_pkg::SYMBOL_WIDTH-1:0]   symbol_ff, symbol_in;
   logic                               last_ff, last_in;
   logic                               error_ff, error_in;

   d2r_pkg::step_type                  entry;
   logic [d2r_pkg::VALUE_WIDTH-1:0]    amount;
   logic [d2r_pkg::VALUE_WIDTH-1:0]    diff;
   logic                               fits;
   logic                               done;

   // shared compare/subtract unit
   assign entry  = d2r_pkg::step_entry(index_ff);
   assign amount = {{(d2r_pkg::VALUE_WIDTH - d2r_pkg::STEP_WIDTH){1'b0}}, entry.amount};
   assign fits   = rem_ff >= amount;
   assign diff   = rem_ff - amount;
   assign done   = diff == '0;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      index_in     = index_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      valid_in     = 1'b0;
      symbol_in    = symbol_ff;
      last_in      = 1'b0;
      error_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_value >= d2r_pkg::VALUE_LIMIT) begin
                  valid_in  = 1'b1;
                  symbol_in = d2r_pkg::SYM_NONE;
                  last_in   = 1'b1;
                  error_in  = 1'b1;
               end else if (req_value == '0) begin
                  valid_in  = 1'b1;
                  symbol_in = d2r_pkg::SYM_N;
                  last_in   = 1'b1;
               end else begin
                  rem_in   = req_value;
                  index_in = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (fits) begin
               rem_in    = diff;
               valid_in  = 1'b1;
               symbol_in = entry.first;
               if (entry.pair) begin
                  pend_in      = entry.second;
                  pend_last_in = done;
                  state_in     = ST_SECOND;
               end else begin
                  last_in = done;
                  if (done) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (index_ff != d2r_pkg::LAST_INDEX) begin
               index_in = index_ff + 1'b1;
            end
         end
         ST_SECOND: begin
            valid_in  = 1'b1;
            symbol_in = pend_ff;
            last_in   = pend_last_ff;
            index_in  = index_ff + 1'b1;
            state_in  = pend_last_ff ? ST_IDLE : ST_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      rem_ff       <= rem_in;
      index_ff     <= index_in;
      pend_ff      <= pend_in;
      pend_last_ff <= pend_last_in;
      symbol_ff    <= symbol_in;
      last_ff      <= last_in;
      error_ff     <= error_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_valid  = valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last   = last_ff;
   assign rsp_error  = error_ff;

endmodule
